FILE: rtl/core/alpn_list_parse_and_select_macros.svh
// assertion helpers shared by the alpn select rtl
`ifndef ALPN_LIST_PARSE_AND_SELECT_MACROS_SVH
`define ALPN_LIST_PARSE_AND_SELECT_MACROS_SVH

// same-cycle implication, reset-qualified
`define ALPN_SEL_ASSERT_IMM(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alpn select check failed");

// next-cycle implication, reset-qualified
`define ALPN_SEL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alpn select check failed");

`endif

FILE: rtl/core/alpn_sel_pkg.sv
package alpn_sel_pkg;

  localparam int unsigned SLOTS_DEF      = 4;
  localparam int unsigned NAME_BYTES_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0]  CHAR_MIN_OK = 8'h21;
  localparam logic [7:0]  CHAR_MAX_OK = 8'h7E;

  localparam logic [7:0]  MAX_NAME_LEN_RST   = 8'd255;
  localparam logic [7:0]  MAX_NAME_COUNT_RST = 8'd32;
  localparam logic [15:0] MAX_LIST_BYTES_RST = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_NAME_LEN   = 4'd0,
    REG_MAX_NAME_COUNT = 4'd1,
    REG_MAX_LIST_BYTES = 4'd2,
    REG_SLOT_LENGTHS   = 4'd3,
    REG_SLOT_NAME_0    = 4'd4,
    REG_SLOT_NAME_1    = 4'd5,
    REG_SLOT_NAME_2    = 4'd6,
    REG_SLOT_NAME_3    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       ack;
    logic [1:0] slot;
    logic [3:0] len;
  } res_t;

endpackage

FILE: rtl/core/alpn_sel_match.sv
module alpn_sel_match #(
  parameter int unsigned SLOTS      = alpn_sel_pkg::SLOTS_DEF,
  parameter int unsigned NAME_BYTES = alpn_sel_pkg::NAME_BYTES_DEF
) (
  input  logic [SLOTS-1:0][3:0]                 slot_len_i,
  input  logic [SLOTS-1:0][NAME_BYTES-1:0][7:0] slot_name_i,
  input  logic [7:0]                            wire_byte_i,
  input  logic [7:0]                            name_pos_i,
  output logic [SLOTS-1:0]                      len_hit_o,
  output logic [SLOTS-1:0]                      byte_hit_o
);

  // slot usable and same length as the byte taken as a length
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      len_hit_o[i] = (slot_len_i[i] != 4'd0) &&
                     (slot_len_i[i] <= 4'(NAME_BYTES)) &&
                     ({4'd0, slot_len_i[i]} == wire_byte_i);
    end
  end

  // slot byte at the current name position equals the incoming byte
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      byte_hit_o[i] = 1'b0;
      for (int k = 0; k < NAME_BYTES; k++) begin
        if (name_pos_i == 8'(k) && slot_name_i[i][k] == wire_byte_i) begin
          byte_hit_o[i] = 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/alpn_sel_parse.sv
`include "alpn_list_parse_and_select_macros.svh"

module alpn_sel_parse #(
  parameter int unsigned SLOTS      = alpn_sel_pkg::SLOTS_DEF,
  parameter int unsigned NAME_BYTES = alpn_sel_pkg::NAME_BYTES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_en_i,
  input  alpn_sel_pkg::item_t                   item_i,
  input  logic [7:0]                            max_name_len_i,
  input  logic [7:0]                            max_name_count_i,
  input  logic [15:0]                           max_list_bytes_i,
  input  logic [SLOTS-1:0][3:0]                 slot_len_i,
  input  logic [SLOTS-1:0][NAME_BYTES-1:0][7:0] slot_name_i,
  output alpn_sel_pkg::res_t                    res_o
);

  logic             in_name_q, in_name_d;
  logic [7:0]       bytes_left_q, bytes_left_d;
  logic [7:0]       name_pos_q, name_pos_d;
  logic [SLOTS-1:0] cand_q, cand_d;
  logic [SLOTS-1:0] matched_q, matched_d;
  logic [7:0]       names_seen_q, names_seen_d;
  logic [15:0]      list_total_q, list_total_d;
  logic             list_bad_q, list_bad_d;

  logic [SLOTS-1:0] len_hit;
  logic [SLOTS-1:0] byte_hit;
  logic [16:0]      grown_total;
  logic             byte_ok;
  logic             final_bad;

  alpn_sel_match #(
    .SLOTS      (SLOTS),
    .NAME_BYTES (NAME_BYTES)
  ) u_match (
    .slot_len_i  (slot_len_i),
    .slot_name_i (slot_name_i),
    .wire_byte_i (item_i.wire_byte),
    .name_pos_i  (name_pos_q),
    .len_hit_o   (len_hit),
    .byte_hit_o  (byte_hit)
  );

  assign byte_ok = (item_i.wire_byte >= alpn_sel_pkg::CHAR_MIN_OK) &&
                   (item_i.wire_byte <= alpn_sel_pkg::CHAR_MAX_OK);

  always_comb begin
    in_name_d    = in_name_q;
    bytes_left_d = bytes_left_q;
    name_pos_d   = name_pos_q;
    cand_d       = cand_q;
    matched_d    = matched_q;
    names_seen_d = names_seen_q;
    list_total_d = list_total_q;
    list_bad_d   = list_bad_q;
    grown_total  = {1'b0, list_total_q} + {9'd0, item_i.wire_byte} + 17'd1;
    if (!list_bad_q) begin
      if (!in_name_q) begin
        if (names_seen_q >= max_name_count_i || item_i.wire_byte == 8'd0 ||
            item_i.wire_byte > max_name_len_i) begin
          list_bad_d = 1'b1;
        end else if (grown_total > {1'b0, max_list_bytes_i}) begin
          list_bad_d = 1'b1;
        end else begin
          list_total_d = grown_total[15:0];
          names_seen_d = (names_seen_q != 8'hFF) ? names_seen_q + 8'd1 : names_seen_q;
          in_name_d    = 1'b1;
          bytes_left_d = item_i.wire_byte;
          name_pos_d   = 8'd0;
          cand_d       = len_hit;
        end
      end else begin
        if (!byte_ok) begin
          list_bad_d = 1'b1;
        end else begin
          cand_d       = cand_q & byte_hit;
          name_pos_d   = name_pos_q + 8'd1;
          bytes_left_d = bytes_left_q - 8'd1;
          if (bytes_left_d == 8'd0) begin
            matched_d = matched_q | cand_d;
            cand_d    = '0;
            in_name_d = 1'b0;
          end
        end
      end
    end
  end

  // ending inside an entry rejects the list; lowest matched slot wins
  assign final_bad = list_bad_d | in_name_d;

  always_comb begin
    res_o = '0;
    if (!final_bad) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (matched_d[i]) begin
          res_o.ack  = 1'b1;
          res_o.slot = 2'(i);
          res_o.len  = slot_len_i[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_name_q    <= 1'b0;
      bytes_left_q <= '0;
      name_pos_q   <= '0;
      cand_q       <= '0;
      matched_q    <= '0;
      names_seen_q <= '0;
      list_total_q <= '0;
      list_bad_q   <= 1'b0;
    end else if (step_en_i) begin
      if (item_i.last_byte) begin
        in_name_q    <= 1'b0;
        bytes_left_q <= '0;
        name_pos_q   <= '0;
        cand_q       <= '0;
        matched_q    <= '0;
        names_seen_q <= '0;
        list_total_q <= '0;
        list_bad_q   <= 1'b0;
      end else begin
        in_name_q    <= in_name_d;
        bytes_left_q <= bytes_left_d;
        name_pos_q   <= name_pos_d;
        cand_q       <= cand_d;
        matched_q    <= matched_d;
        names_seen_q <= names_seen_d;
        list_total_q <= list_total_d;
        list_bad_q   <= list_bad_d;
      end
    end
  end

  `ALPN_SEL_ASSERT_IMM(a_name_owes_bytes, clk_i, rst_ni, in_name_q, bytes_left_q != 8'd0)
  `ALPN_SEL_ASSERT_IMM(a_no_cand_between, clk_i, rst_ni, !in_name_q, cand_q == '0)
  `ALPN_SEL_ASSERT_NXT(a_zero_len_rejects, clk_i, rst_ni,
                       step_en_i && !list_bad_q && !in_name_q && !item_i.last_byte &&
                       item_i.wire_byte == 8'd0, list_bad_q)

endmodule

FILE: rtl/core/alpn_list_parse_and_select.sv
// alpn list parser and server protocol selector. the client list arrives one
// byte per word on the input channel (a length byte, then that many name
// bytes, repeated; last_byte marks the end of the list). the block takes one
// byte every cycle unless the input stalls: each byte passes an input register
// and the parse and compare logic against up to SLOTS configured names of up
// to NAME_BYTES bytes, and a last byte then lands in the result register, which
// offers the result. only the last byte of a list produces a result word:
// acknowledged with the lowest matching slot and its length, or no
// acknowledgement when nothing matched or the list broke a rule. the input
// stalls only while a last byte waits behind a result that is itself stalled.
// after each result the parse state is cleared and the next byte starts a new
// list. configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i, by the user only while the block is idle; the block itself does
// not enforce this. indexes beyond the register list are ignored.
`include "alpn_list_parse_and_select_macros.svh"

module alpn_list_parse_and_select #(
  parameter int unsigned SLOTS      = alpn_sel_pkg::SLOTS_DEF,
  parameter int unsigned NAME_BYTES = alpn_sel_pkg::NAME_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [alpn_sel_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alpn_sel_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // list byte channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         wire_byte_i,
  input  logic                               last_byte_i,
  // selection result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               acknowledged_o,
  output logic [1:0]                         chosen_slot_o,
  output logic [3:0]                         chosen_len_o
);

  // configuration registers
  logic [7:0]                            max_name_len_q;
  logic [7:0]                            max_name_count_q;
  logic [15:0]                           max_list_bytes_q;
  logic [SLOTS-1:0][3:0]                 slot_len_q;
  logic [SLOTS-1:0][NAME_BYTES-1:0][7:0] slot_name_q;

  // input register
  logic                in_valid_q;
  alpn_sel_pkg::item_t in_item_q;

  // result register
  logic               out_valid_q;
  alpn_sel_pkg::res_t out_res_q;
  alpn_sel_pkg::res_t parse_res;

  logic s1_go;
  logic in_take;

  // scalar register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_len_q   <= alpn_sel_pkg::MAX_NAME_LEN_RST;
      max_name_count_q <= alpn_sel_pkg::MAX_NAME_COUNT_RST;
      max_list_bytes_q <= alpn_sel_pkg::MAX_LIST_BYTES_RST;
      slot_len_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alpn_sel_pkg::REG_MAX_NAME_LEN:   max_name_len_q   <= cfg_wdata_i[7:0];
        alpn_sel_pkg::REG_MAX_NAME_COUNT: max_name_count_q <= cfg_wdata_i[7:0];
        alpn_sel_pkg::REG_MAX_LIST_BYTES: max_list_bytes_q <= cfg_wdata_i[15:0];
        alpn_sel_pkg::REG_SLOT_LENGTHS: begin
          // one nibble per slot, slots past SLOTS dropped
          for (int i = 0; i < SLOTS; i++) begin
            slot_len_q[i] <= cfg_wdata_i[4*i +: 4];
          end
        end
        default: ;
      endcase
    end
  end

  // slot name writes, byte 0 of the name in the low byte of the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_name_q <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cfg_idx_i == alpn_sel_pkg::CFG_IDX_W'(alpn_sel_pkg::REG_SLOT_NAME_0 + i)) begin
          slot_name_q[i] <= cfg_wdata_i[NAME_BYTES*8-1:0];
        end
      end
    end
  end

  // the held byte moves on unless it is a last byte facing a stalled result
  assign s1_go      = in_valid_q && (!in_item_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (s1_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.wire_byte <= wire_byte_i;
      in_item_q.last_byte <= last_byte_i;
    end
  end

  alpn_sel_parse #(
    .SLOTS      (SLOTS),
    .NAME_BYTES (NAME_BYTES)
  ) u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_en_i        (s1_go),
    .item_i           (in_item_q),
    .max_name_len_i   (max_name_len_q),
    .max_name_count_i (max_name_count_q),
    .max_list_bytes_i (max_list_bytes_q),
    .slot_len_i       (slot_len_q),
    .slot_name_i      (slot_name_q),
    .res_o            (parse_res)
  );

  // result register, loaded only by a last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && in_item_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && in_item_q.last_byte) begin
      out_res_q <= parse_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign acknowledged_o = out_res_q.ack;
  assign chosen_slot_o  = out_res_q.slot;
  assign chosen_len_o   = out_res_q.len;

  `ALPN_SEL_ASSERT_IMM(a_stall_cause, clk_i, rst_ni, in_stall_o,
                       in_valid_q && in_item_q.last_byte && out_valid_q && out_stall_i)
  `ALPN_SEL_ASSERT_NXT(a_last_gives_result, clk_i, rst_ni,
                       s1_go && in_item_q.last_byte, out_valid_q)
  `ALPN_SEL_ASSERT_IMM(a_nack_zero, clk_i, rst_ni, out_valid_q && !out_res_q.ack,
                       out_res_q.slot == 2'd0 && out_res_q.len == 4'd0)
  `ALPN_SEL_ASSERT_IMM(a_ack_len, clk_i, rst_ni, out_valid_q && out_res_q.ack,
                       out_res_q.len != 4'd0 && out_res_q.len <= 4'(NAME_BYTES))

endmodule
